@@ hw/rtl/swm_pkg.sv @@
// shared constants and types for the sliding window maximum block
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH        = 7;

    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = CFG_WIDTH'(1);

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic en;
        logic start;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/swm_cell.sv @@
// one cell of the chain: holds the maximum of the last k+1 samples of the sequence
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire t_cell_ctl                 i_ctl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_smp,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_prev,
    output logic signed [SAMPLE_WIDTH-1:0] o_val
);

    logic signed [SAMPLE_WIDTH-1:0] r_val;
    logic signed [SAMPLE_WIDTH-1:0] n_val;

    // a new sequence restarts every running maximum at its first sample
    always_comb begin
        if (i_ctl.start) begin
            n_val = i_smp;
        end else if (i_smp > i_prev) begin
            n_val = i_smp;
        end else begin
            n_val = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

@@ hw/rtl/swm_select.sv @@
// output stage: picks the cell for the current window and registers it
`default_nettype none

module swm_select
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  wire                                 i_clk,
    input  wire logic                           i_load,
    input  wire logic [IW-1:0]                  i_sel,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_cells [WINDOW_MAX],
    output logic signed [SAMPLE_WIDTH-1:0]      o_data
);

    logic signed [SAMPLE_WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_cells[i_sel];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

@@ hw/rtl/sliding_window_maximum.sv @@
// sliding window maximum: top level with the cell chain, control and output stage
// an accepted item updates the cells and pending flag; the output register loads when not held
// throughput: one item per cycle while the output is not held, set by the single compare in each cell
// the chain updates every cell on each accepted item; no memory, no clearing pass
// reset (synchronous, active low) clears fill count, pending flags and window to 1
`default_nettype none

module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_WIDTH-1:0]  i_cfg_wdata,   // window_size
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire [DW-1:0]         s_axis_tdata,  // sample, zero padding
    input  wire                  s_axis_tuser,  // start_req
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [DW-1:0]        m_axis_tdata   // window_max, zero padding
);

    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (CFG_WIDTH > FW) ? CFG_WIDTH : FW;
    localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);
    localparam logic [FW-1:0] WMAX_F = FW'(WINDOW_MAX);

    logic [CFG_WIDTH-1:0] r_window;
    logic [FW-1:0]        r_fill;
    logic [FW-1:0]        n_fill;
    logic [FW-1:0]        fill_base;
    logic                 r_pend;
    logic                 r_ovld;
    logic [IW-1:0]        r_sel;
    logic [CW-1:0]        win_ext;
    logic [CW-1:0]        eff_w;
    logic [CW-1:0]        eff_m1;
    logic                 in_acc;
    logic                 move;
    logic                 has_res;
    t_cell_ctl            cell_ctl;

    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [SAMPLE_WIDTH-1:0] cells [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] out_data;

    assign smp = s_axis_tdata[SAMPLE_WIDTH-1:0];

    // window zero acts as one, above the chain length acts as the chain length
    assign win_ext = CW'(r_window);
    always_comb begin
        if (win_ext == '0) begin
            eff_w = CW'(1);
        end else if (win_ext > WMAX_C) begin
            eff_w = WMAX_C;
        end else begin
            eff_w = win_ext;
        end
    end
    assign eff_m1 = eff_w - CW'(1);

    // the pending result is read from the cells as they were before this edge
    assign move          = r_pend && (!r_ovld || m_axis_tready);
    assign s_axis_tready = !r_pend || move;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign fill_base = s_axis_tuser ? '0 : r_fill;
    assign n_fill    = (fill_base < WMAX_F) ? fill_base + FW'(1) : fill_base;
    assign has_res   = CW'(n_fill) >= eff_w;

    assign cell_ctl.en    = in_acc;
    assign cell_ctl.start = s_axis_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_fill   <= '0;
            r_pend   <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_fill <= n_fill;
                r_pend <= has_res;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sel <= eff_m1[IW-1:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
            if (k == 0) begin : g_head
                swm_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
                    .i_clk  (i_clk),
                    .i_ctl  (cell_ctl),
                    .i_smp  (smp),
                    .i_prev (smp),
                    .o_val  (cells[k])
                );
            end else begin : g_body
                swm_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
                    .i_clk  (i_clk),
                    .i_ctl  (cell_ctl),
                    .i_smp  (smp),
                    .i_prev (cells[k-1]),
                    .o_val  (cells[k])
                );
            end
        end
    endgenerate

    swm_select #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_select (
        .i_clk   (i_clk),
        .i_load  (move),
        .i_sel   (r_sel),
        .i_cells (cells),
        .o_data  (out_data)
    );

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = DW'($unsigned(out_data));

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WMAX_F)
        else $error("fill count beyond chain length");

    a_start_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser && (eff_w == CW'(1)) |=> r_pend)
        else $error("start item with window one gave no result");

    a_start_wide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser && (eff_w > CW'(1)) |=> !r_pend)
        else $error("start item with wide window gave a result");

    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> m_axis_tvalid)
        else $error("pending result not shown on output");

endmodule

`default_nettype wire
